[rtl/core/pscg_pkg.sv]
// pscg_pkg: shared types, codes and constants of the pen stroke command generator
// used by every module under rtl/core; depends on nothing else

package pscg_pkg;

	// coordinate and field widths
	localparam int COORD_W   = 13;
	localparam int OUT_W     = 14;
	localparam int RAD_W     = 6;
	localparam int PRESS_W   = 12;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 13;
	localparam int TRAIL_W   = 2 * COORD_W + RAD_W;

	// parameter defaults
	localparam int TRAIL_DEPTH_DEF     = 11;
	localparam int DIGITIZER_MAX_X_DEF = 11180;
	localparam int DIGITIZER_MAX_Y_DEF = 15340;

	// event classes and codes
	localparam logic [4:0] EV_SYN = 5'd0;
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_ABS = 5'd3;

	localparam logic [9:0] CODE_SYN_REPORT = 10'd0;
	localparam logic [9:0] CODE_ABS_X      = 10'd0;
	localparam logic [9:0] CODE_ABS_Y      = 10'd1;
	localparam logic [9:0] CODE_ABS_PRESS  = 10'd24;
	localparam logic [9:0] CODE_KEY_RUBBER = 10'd321;
	localparam logic [9:0] CODE_KEY_TOUCH  = 10'd330;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOOT_SPC  = 4'd3;

	// drawing constants
	localparam logic [PRESS_W-1:0] PRESS_MAX     = 12'd4095;
	localparam logic [RAD_W-1:0]   RADIUS_ERASER = 6'd22;
	localparam logic [RAD_W-1:0]   RADIUS_BASE   = 6'd2;
	localparam logic [RAD_W-1:0]   TRAIL_PAD     = 6'd13;
	localparam logic [OUT_W-1:0]   FOOT_DX       = 14'd52;
	localparam logic [OUT_W-1:0]   FOOT_DY       = 14'd38;
	localparam logic [OUT_W-1:0]   COORD_SAT     = 14'd8191;

	typedef enum logic [1:0] {
		CMD_DOT    = 2'd0,
		CMD_LINE   = 2'd1,
		CMD_SPRITE = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIST,
		ST_DECIDE
	} job_state_t;

	typedef struct packed {
		cmd_e                     command;
		logic                     ink_black;
		logic signed [OUT_W-1:0]  start_x;
		logic signed [OUT_W-1:0]  start_y;
		logic signed [OUT_W-1:0]  end_x;
		logic signed [OUT_W-1:0]  end_y;
		logic [RAD_W-1:0]         radius;
		logic                     sprite_side;
	} cmd_t;

	typedef cmd_t [2:0] cmd_list_t;

	// axis clamp: negative to zero, above hi to hi
	function automatic logic [15:0] clamp_axis(logic signed [15:0] v, logic [15:0] hi);
		logic [15:0] r;
		if (v[15]) begin
			r = 16'd0;
		end else if ({1'b0, v[14:0]} > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/core/pscg_trail_mem.sv]
// pscg_trail_mem: trail ring storage, one write port and two registered read ports
// uses pscg_pkg for the entry width

module pscg_trail_mem #(
	parameter int DEPTH = pscg_pkg::TRAIL_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic [pscg_pkg::TRAIL_W-1:0]      wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          raddr_a,
	input  logic [$clog2(DEPTH)-1:0]          raddr_b,
	output logic [pscg_pkg::TRAIL_W-1:0]      rdata_a,
	output logic [pscg_pkg::TRAIL_W-1:0]      rdata_b
);
	import pscg_pkg::*;

	logic [TRAIL_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[rtl/core/pscg_scaler.sv]
// pscg_scaler: four-stage pipeline, raw * (size - 1) / MAX_RAW by reciprocal and correction
// uses pscg_pkg for the coordinate width

module pscg_scaler #(
	parameter int MAX_RAW = pscg_pkg::DIGITIZER_MAX_X_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [$clog2(MAX_RAW+1)-1:0]       raw,
	input  logic [pscg_pkg::COORD_W-1:0]       size_m1,
	output logic                               done,
	output logic [pscg_pkg::COORD_W-1:0]       coord
);
	import pscg_pkg::*;

	localparam int RAW_W  = $clog2(MAX_RAW + 1);
	localparam int PROD_W = RAW_W + COORD_W;
	localparam int SHIFT  = PROD_W;
	localparam int RCP_W  = SHIFT + 1;
	localparam logic [RCP_W-1:0] RECIP   = RCP_W'((64'd1 << SHIFT) / MAX_RAW);
	localparam logic [RAW_W-1:0] DIVISOR = RAW_W'(MAX_RAW);

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic [PROD_W-1:0]         prod_s1, prod_s2, prod_s3;
	logic [PROD_W+RCP_W-1:0]   rcp_mul;
	logic [COORD_W-1:0]        est_s2, est_s3;
	logic [PROD_W-1:0]         estd_s3;
	logic [PROD_W-1:0]         rem;

	assign rcp_mul = PROD_W'(prod_s1) * RECIP;
	assign rem     = prod_s3 - estd_s3;

	// stage valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// product, reciprocal estimate, back-multiply, one-step correction
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(raw * size_m1);
		prod_s2 <= prod_s1;
		est_s2  <= rcp_mul[SHIFT+COORD_W-1:SHIFT];
		prod_s3 <= prod_s2;
		est_s3  <= est_s2;
		estd_s3 <= PROD_W'(est_s2 * DIVISOR);
		coord   <= est_s3 + COORD_W'(rem >= PROD_W'(DIVISOR));
	end

	assign done = v_s4;

endmodule

[rtl/core/pscg_emit.sv]
// pscg_emit: holds up to three commands of a report; sends one per cycle while m_axis_tready is high
// uses pscg_pkg for the command record

module pscg_emit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  pscg_pkg::cmd_list_t     cmds,
	input  logic [1:0]              count,
	output logic                    active,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [63:0]             m_axis_tdata,  // ink_black, start_x, start_y, end_x, end_y, radius, sprite_side
	output logic [1:0]              m_axis_tuser,  // command
	output logic                    m_axis_tlast
);
	import pscg_pkg::*;

	cmd_list_t   queue_q;
	logic [1:0]  count_q;
	logic [1:0]  idx_q;
	logic        active_q;
	logic        out_valid_q;
	cmd_t        out_q;
	logic        last_q;
	logic        take;
	logic        at_last;

	assign take    = !out_valid_q || m_axis_tready;
	assign at_last = idx_q == (count_q - 2'd1);

	// queue control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			count_q     <= 2'd0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q    <= 2'd0;
			count_q  <= count;
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end else if (active_q && take) begin
			out_valid_q <= 1'b1;
			idx_q       <= idx_q + 2'd1;
			if (at_last) begin
				active_q <= 1'b0;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			queue_q <= cmds;
		end else if (active_q && take) begin
			out_q  <= queue_q[idx_q];
			last_q <= at_last;
		end
	end

	assign active        = active_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.command;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {out_q.sprite_side, out_q.radius, out_q.end_y, out_q.end_x,
		out_q.start_y, out_q.start_x, out_q.ink_black};

endmodule

[rtl/core/pen_stroke_command_generator_unit.sv]
// pen_stroke_command_generator_unit: top level of the pen stroke command generator
// uses pscg_pkg, pscg_scaler, pscg_trail_mem and pscg_emit
//
// Usage:
// s_axis carries digitizer events: tuser is the event type, tdata holds code and value.
// m_axis carries drawing commands: tuser is the command, tlast marks the final command
// of a sync report. The cfg channel writes screen size, pressure threshold and
// footprint spacing; cfg_ready is always high, writes belong to idle periods.
// Axis and key events are taken one per cycle and produce no command.
// A sync report that draws starts a job: both coordinates run through the four-stage
// reciprocal scaler, then the job passes the distance squares state and the decision
// and trail ring write-back state; the commands, up to three, then leave m_axis one per
// cycle while m_axis_tready is high. The job keeps the block busy until all its
// commands have moved into the output register; further axis and key events are still
// taken meanwhile, a sync waits until then.
// The trail ring is a small memory read at the two oldest entries when the job starts
// and, for a pen job, written at the oldest entry when the job decides.
// When the receiver stalls, commands wait in the output register and the queue; axis
// and key events are still taken. Reset clears pen state, stroke, anchor and trail
// bookkeeping and loads default configuration; trail memory contents need no clearing.

module pen_stroke_command_generator_unit #(
	parameter int TRAIL_DEPTH     = pscg_pkg::TRAIL_DEPTH_DEF,
	parameter int DIGITIZER_MAX_X = pscg_pkg::DIGITIZER_MAX_X_DEF,
	parameter int DIGITIZER_MAX_Y = pscg_pkg::DIGITIZER_MAX_Y_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [31:0]                      s_axis_tdata,  // event_code, event_value
	input  logic [4:0]                       s_axis_tuser,  // event_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [63:0]                      m_axis_tdata,  // ink_black, start_x, start_y, end_x, end_y, radius, sprite_side
	output logic [1:0]                       m_axis_tuser,  // command
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pscg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pscg_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import pscg_pkg::*;

	localparam int RAWX_W = $clog2(DIGITIZER_MAX_X + 1);
	localparam int RAWY_W = $clog2(DIGITIZER_MAX_Y + 1);
	localparam int HEAD_W = $clog2(TRAIL_DEPTH);
	localparam int CNT_W  = $clog2(TRAIL_DEPTH + 1);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TRAIL_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(TRAIL_DEPTH);

	// event fields
	logic [4:0]         ev_type;
	logic [9:0]         ev_code;
	logic signed [15:0] ev_value;
	logic               in_accept;
	logic               is_sync;
	logic               draw_now;
	logic               job_start;
	logic               clear_now;
	logic               busy;
	logic               emit_active;
	logic [15:0]        clamp_x, clamp_y, clamp_p;

	// configuration
	logic [COORD_W-1:0] screen_w_q, screen_h_q;
	logic [PRESS_W-1:0] press_thr_q, foot_spc_q;
	logic [COORD_W-1:0] size_x_m1, size_y_m1;

	// pen state
	logic [RAWX_W-1:0]  raw_x_q;
	logic [RAWY_W-1:0]  raw_y_q;
	logic [PRESS_W-1:0] pressure_q;
	logic               pen_down_q, eraser_q, pending_q;
	logic               prev_valid_q, anchor_valid_q, parity_q;
	logic [COORD_W-1:0] prev_x_q, prev_y_q, anchor_x_q, anchor_y_q;
	logic [CNT_W-1:0]   trail_cnt_q;
	logic [HEAD_W-1:0]  trail_head_q, head_next;
	logic               trail_full;

	// job registers
	job_state_t         state_q, state_d;
	logic               job_eraser_q, job_full_q;
	logic [PRESS_W-1:0] job_press_q;
	logic [HEAD_W-1:0]  job_head_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [26:0]        sq_x_q, sq_y_q;
	logic [23:0]        spc_sq_q;
	logic [RAD_W-1:0]   radius_q;
	logic               scale_done_x, scale_done_y;
	logic [COORD_W-1:0] scale_x, scale_y;

	// decision
	logic signed [OUT_W-1:0] dx, dy;
	logic signed [27:0]      dx_sq, dy_sq;
	logic [13:0]             press3;
	logic [27:0]             dist_sum;
	logic                    step;
	logic [OUT_W-1:0]        foot_x_raw, foot_x;
	logic signed [OUT_W-1:0] sx, sy;
	logic [TRAIL_W-1:0]      rd_old, rd_next, wr_entry;
	logic                    load_cmds;
	cmd_list_t               cmds;
	logic [1:0]              cmd_count;
	cmd_t                    c_stroke, c_foot, c_erase;

	assign ev_type   = s_axis_tuser;
	assign ev_code   = s_axis_tdata[9:0];
	assign ev_value  = $signed(s_axis_tdata[25:10]);
	assign is_sync   = (ev_type == EV_SYN) && (ev_code == CODE_SYN_REPORT);
	assign busy      = (state_q != ST_IDLE) || emit_active;
	assign s_axis_tready = !(busy && is_sync);
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign draw_now  = pen_down_q && (pressure_q > press_thr_q);
	assign job_start = in_accept && is_sync && pending_q && draw_now;
	assign clear_now = in_accept && is_sync && pending_q && !draw_now;
	assign cfg_ready = 1'b1;

	assign clamp_x = clamp_axis(ev_value, 16'(DIGITIZER_MAX_X));
	assign clamp_y = clamp_axis(ev_value, 16'(DIGITIZER_MAX_Y));
	assign clamp_p = clamp_axis(ev_value, 16'(PRESS_MAX));

	assign size_x_m1  = (screen_w_q == '0) ? '0 : screen_w_q - COORD_W'(1);
	assign size_y_m1  = (screen_h_q == '0) ? '0 : screen_h_q - COORD_W'(1);
	assign trail_full = trail_cnt_q == CNT_FULL;
	assign head_next  = (trail_head_q == HEAD_LAST) ? '0 : trail_head_q + HEAD_W'(1);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q  <= 13'd1404;
			screen_h_q  <= 13'd1872;
			press_thr_q <= 12'd40;
			foot_spc_q  <= 12'd120;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCREEN_W:  screen_w_q  <= cfg_data;
				CFG_SCREEN_H:  screen_h_q  <= cfg_data;
				CFG_PRESS_THR: press_thr_q <= cfg_data[PRESS_W-1:0];
				CFG_FOOT_SPC:  foot_spc_q  <= cfg_data[PRESS_W-1:0];
				default: ;
			endcase
		end
	end

	// event decode and pen state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_x_q    <= '0;
			raw_y_q    <= '0;
			pressure_q <= '0;
			pen_down_q <= 1'b0;
			eraser_q   <= 1'b0;
			pending_q  <= 1'b0;
		end else if (in_accept) begin
			case (ev_type)
				EV_ABS: begin
					if (ev_code == CODE_ABS_X) begin
						raw_x_q   <= clamp_x[RAWX_W-1:0];
						pending_q <= 1'b1;
					end else if (ev_code == CODE_ABS_Y) begin
						raw_y_q   <= clamp_y[RAWY_W-1:0];
						pending_q <= 1'b1;
					end else if (ev_code == CODE_ABS_PRESS) begin
						pressure_q <= clamp_p[PRESS_W-1:0];
						pending_q  <= 1'b1;
					end
				end
				EV_KEY: begin
					if (ev_code == CODE_KEY_RUBBER) begin
						eraser_q <= ev_value != '0;
					end else if (ev_code == CODE_KEY_TOUCH) begin
						pen_down_q <= ev_value != '0;
						pending_q  <= 1'b1;
					end
				end
				EV_SYN: begin
					if (ev_code == CODE_SYN_REPORT) begin
						pending_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// stroke, anchor and trail bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q   <= 1'b0;
			anchor_valid_q <= 1'b0;
			parity_q       <= 1'b0;
			trail_cnt_q    <= '0;
			trail_head_q   <= '0;
		end else if (clear_now) begin
			prev_valid_q   <= 1'b0;
			anchor_valid_q <= 1'b0;
			trail_cnt_q    <= '0;
			trail_head_q   <= '0;
		end else if (job_start && !eraser_q) begin
			trail_head_q <= head_next;
			if (!trail_full) begin
				trail_cnt_q <= trail_cnt_q + CNT_W'(1);
			end
		end else if (state_q == ST_DECIDE) begin
			prev_valid_q <= 1'b1;
			if (!job_eraser_q && step) begin
				anchor_valid_q <= 1'b1;
				parity_q       <= ~parity_q;
			end
		end
	end

	// stroke and anchor coordinates
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			prev_x_q <= x_q;
			prev_y_q <= y_q;
			if (!job_eraser_q && step) begin
				anchor_x_q <= x_q;
				anchor_y_q <= y_q;
			end
		end
	end

	// job state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// job next state
	always_comb begin
		state_d   = state_q;
		load_cmds = 1'b0;
		case (state_q)
			ST_IDLE:   if (job_start) state_d = ST_SCALE;
			ST_SCALE:  if (scale_done_x) state_d = ST_DIST;
			ST_DIST:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				load_cmds = 1'b1;
				state_d   = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// coordinate scaling
	pscg_scaler #(.MAX_RAW(DIGITIZER_MAX_X)) u_scale_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (job_start),
		.raw     (raw_x_q),
		.size_m1 (size_x_m1),
		.done    (scale_done_x),
		.coord   (scale_x)
	);

	pscg_scaler #(.MAX_RAW(DIGITIZER_MAX_Y)) u_scale_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (job_start),
		.raw     (raw_y_q),
		.size_m1 (size_y_m1),
		.done    (scale_done_y),
		.coord   (scale_y)
	);

	// trail ring
	pscg_trail_mem #(.DEPTH(TRAIL_DEPTH)) u_trail (
		.clk     (clk),
		.we      ((state_q == ST_DECIDE) && !job_eraser_q),
		.waddr   (job_head_q),
		.wdata   (wr_entry),
		.re      (job_start),
		.raddr_a (trail_head_q),
		.raddr_b (head_next),
		.rdata_a (rd_old),
		.rdata_b (rd_next)
	);

	// job snapshot, scaled point, squares
	assign dx     = $signed({1'b0, x_q}) - $signed({1'b0, anchor_x_q});
	assign dy     = $signed({1'b0, y_q}) - $signed({1'b0, anchor_y_q});
	assign dx_sq  = dx * dx;
	assign dy_sq  = dy * dy;
	assign press3 = 14'(job_press_q * 2'd3);

	always_ff @(posedge clk) begin
		if (job_start) begin
			job_eraser_q <= eraser_q;
			job_full_q   <= trail_full;
			job_press_q  <= pressure_q;
			job_head_q   <= trail_head_q;
		end
		if (state_q == ST_SCALE && scale_done_y) begin
			x_q <= scale_x;
			y_q <= scale_y;
		end
		if (state_q == ST_DIST) begin
			sq_x_q   <= dx_sq[26:0];
			sq_y_q   <= dy_sq[26:0];
			spc_sq_q <= 24'(foot_spc_q * foot_spc_q);
			radius_q <= job_eraser_q ? RADIUS_ERASER : RADIUS_BASE + RAD_W'(press3[13:12]);
		end
	end

	// command assembly
	assign dist_sum   = 28'(sq_x_q) + 28'(sq_y_q);
	assign step       = !anchor_valid_q || (dist_sum > 28'(spc_sq_q));
	assign sx         = $signed({1'b0, x_q});
	assign sy         = $signed({1'b0, y_q});
	assign foot_x_raw = {1'b0, x_q} + FOOT_DX;
	assign foot_x     = (foot_x_raw > COORD_SAT) ? COORD_SAT : foot_x_raw;
	assign wr_entry   = {x_q, y_q, radius_q + TRAIL_PAD};

	always_comb begin
		c_stroke.command     = prev_valid_q ? CMD_LINE : CMD_DOT;
		c_stroke.ink_black   = !job_eraser_q;
		c_stroke.start_x     = prev_valid_q ? $signed({1'b0, prev_x_q}) : sx;
		c_stroke.start_y     = prev_valid_q ? $signed({1'b0, prev_y_q}) : sy;
		c_stroke.end_x       = sx;
		c_stroke.end_y       = sy;
		c_stroke.radius      = radius_q;
		c_stroke.sprite_side = 1'b0;

		c_foot.command     = CMD_SPRITE;
		c_foot.ink_black   = 1'b1;
		c_foot.start_x     = $signed(foot_x);
		c_foot.start_y     = sy - $signed(FOOT_DY);
		c_foot.end_x       = $signed(foot_x);
		c_foot.end_y       = sy - $signed(FOOT_DY);
		c_foot.radius      = '0;
		c_foot.sprite_side = parity_q;

		c_erase.command     = CMD_LINE;
		c_erase.ink_black   = 1'b0;
		c_erase.start_x     = $signed({1'b0, rd_old[TRAIL_W-1 -: COORD_W]});
		c_erase.start_y     = $signed({1'b0, rd_old[RAD_W +: COORD_W]});
		c_erase.end_x       = $signed({1'b0, rd_next[TRAIL_W-1 -: COORD_W]});
		c_erase.end_y       = $signed({1'b0, rd_next[RAD_W +: COORD_W]});
		c_erase.radius      = rd_old[RAD_W-1:0];
		c_erase.sprite_side = 1'b0;

		cmds[0]   = c_stroke;
		cmds[1]   = c_erase;
		cmds[2]   = c_erase;
		cmd_count = 2'd1;
		if (!job_eraser_q) begin
			if (step) begin
				cmds[1]   = c_foot;
				cmd_count = 2'd2;
			end
			if (job_full_q) begin
				cmd_count = cmd_count + 2'd1;
			end
		end
	end

	// output queue and register
	pscg_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load_cmds),
		.cmds          (cmds),
		.count         (cmd_count),
		.active        (emit_active),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
